// ----- hw/rtl/uf2ba_pkg.sv -----
// Shared constants, codes and types of the UF2 block acceptor.
`default_nettype none
package uf2ba_pkg;

    localparam int unsigned IMAGE_BYTES = 98304;
    localparam int unsigned PAYLOAD_MAX = 256;
    localparam int unsigned MAX_BLOCKS  = 384;

    localparam logic [31:0] MAGIC_FIRST  = 32'h0A32_4655;
    localparam logic [31:0] MAGIC_SECOND = 32'h9E5D_5157;
    localparam logic [31:0] MAGIC_CLOSE  = 32'h0AB1_6F30;
    localparam logic [31:0] FLAG_FAMILY  = 32'h0000_2000;
    localparam logic [31:0] FAMILY_RESET = 32'hE48B_FF56;
    localparam logic [31:0] BASE_RESET   = 32'h1000_0000;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned OFF_W  = 17;
    localparam int unsigned CNT_W  = 9;
    localparam int unsigned IN_W   = 9 * WORD_W;
    localparam int unsigned OUT_W  = 48;

    // The received map is held as rows of eight flags.
    localparam int unsigned BIT_W    = 3;
    localparam int unsigned ROW_BITS = 1 << BIT_W;
    localparam int unsigned MAP_ROWS = MAX_BLOCKS / ROW_BITS;
    localparam int unsigned ROW_W    = $clog2(MAP_ROWS);

    // Configuration register indexes.
    localparam logic CFG_FAMILY = 1'b0;
    localparam logic CFG_BASE   = 1'b1;

    typedef enum logic [2:0] {
        RSN_OK       = 3'd0,
        RSN_MAGIC    = 3'd1,
        RSN_SIZE     = 3'd2,
        RSN_FAMILY   = 3'd3,
        RSN_BASE     = 3'd4,
        RSN_IMAGE    = 3'd5,
        RSN_TOTAL    = 3'd6,
        RSN_MISMATCH = 3'd7
    } reason_t;

    typedef struct packed {
        logic [WORD_W-1:0] first_magic;
        logic [WORD_W-1:0] second_magic;
        logic [WORD_W-1:0] block_flags;
        logic [WORD_W-1:0] target_address;
        logic [WORD_W-1:0] payload_bytes;
        logic [WORD_W-1:0] block_number;
        logic [WORD_W-1:0] total_blocks;
        logic [WORD_W-1:0] family_word;
        logic [WORD_W-1:0] closing_magic;
    } hdr_t;

    // Outcome of the stateless header checks, handed to the update stage.
    typedef struct packed {
        reason_t          reason;
        logic [OFF_W-1:0] off;
        logic             off_big;
        logic [CNT_W-1:0] psize;
        logic [CNT_W-1:0] bnum;
        logic             total_bad;
        logic [CNT_W-1:0] total;
    } chk_t;

endpackage
`default_nettype wire

// ----- hw/rtl/uf2ba_hdr_check.sv -----
// Stateless header checks: magic words, limits, family, base and the raw write offset.
`default_nettype none
module uf2ba_hdr_check (
    input  var uf2ba_pkg::hdr_t    hdr,
    input  var logic [31:0]        expected_family,
    input  var logic [31:0]        flash_base,
    output var uf2ba_pkg::chk_t    chk
);

    logic [32:0] diff;

    always_comb
    begin
        diff = {1'b0, hdr.target_address} - {1'b0, flash_base};

        chk.off       = diff[uf2ba_pkg::OFF_W-1:0];
        // Any offset of 2^17 or more is past the image whatever the payload size.
        chk.off_big   = |diff[31:uf2ba_pkg::OFF_W];
        chk.psize     = hdr.payload_bytes[uf2ba_pkg::CNT_W-1:0];
        chk.bnum      = hdr.block_number[uf2ba_pkg::CNT_W-1:0];
        chk.total     = hdr.total_blocks[uf2ba_pkg::CNT_W-1:0];
        chk.total_bad = (hdr.total_blocks == '0) ||
                        (hdr.total_blocks > 32'(uf2ba_pkg::MAX_BLOCKS));

        if ((hdr.first_magic != uf2ba_pkg::MAGIC_FIRST) ||
            (hdr.second_magic != uf2ba_pkg::MAGIC_SECOND) ||
            (hdr.closing_magic != uf2ba_pkg::MAGIC_CLOSE))
        begin
            chk.reason = uf2ba_pkg::RSN_MAGIC;
        end
        else if ((hdr.payload_bytes > 32'(uf2ba_pkg::PAYLOAD_MAX)) ||
                 (hdr.block_number >= 32'(uf2ba_pkg::MAX_BLOCKS)))
        begin
            chk.reason = uf2ba_pkg::RSN_SIZE;
        end
        else if (((hdr.block_flags & uf2ba_pkg::FLAG_FAMILY) != '0) &&
                 (hdr.family_word != expected_family))
        begin
            chk.reason = uf2ba_pkg::RSN_FAMILY;
        end
        else if (diff[32])
        begin
            chk.reason = uf2ba_pkg::RSN_BASE;
        end
        else
        begin
            chk.reason = uf2ba_pkg::RSN_OK;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/uf2_block_acceptor.sv -----
// Top level of the UF2 block acceptor: header pipeline, received map memory and session state.
//
// The slave stream takes one UF2 block header per beat on s_tdata; the master stream
// returns one status beat per header on m_tdata. A header passes the check stage register,
// the update stage register and the output register, which drives m_tvalid. One header is
// taken every cycle unless the map is being cleared or the output stalls: the check stage,
// the map read and the update stage overlap, and the status sits in an output register,
// so s_tready can stay high while a result waits to be taken. The rate is set by the
// received-map memory, read in the check stage and written back in the update stage; a
// write followed at once by a read of the same row is served from a forwarding register.
// When m_tready is low the output register holds and the two stages behind it fill;
// s_tready drops only once all three are occupied.
// After reset the map memory is cleared one row per cycle with s_tready low; configuration
// writes are taken throughout. Reset also restores the family id and flash base registers
// and closes the session. cfg_we writes cfg_data into register cfg_index (0 expected
// family, 1 flash base) at once.
`default_nettype none
module uf2_block_acceptor (
    input  var logic                         clk,
    input  var logic                         rst_n,
    input  var logic                         cfg_we,
    input  var logic                         cfg_index,
    input  var logic [31:0]                  cfg_data,
    input  var logic                         s_tvalid,
    output var logic                         s_tready,
    // first_magic, second_magic, block_flags, target_address, payload_bytes,
    // block_number, total_blocks, family_word, closing_magic (32 bits each)
    input  var logic [uf2ba_pkg::IN_W-1:0]   s_tdata,
    output var logic                         m_tvalid,
    input  var logic                         m_tready,
    // accepted[0], reject_reason[3:1], write_offset[20:4], image_length[37:21],
    // blocks_received[46:38], image_complete[47]
    output var logic [uf2ba_pkg::OUT_W-1:0]  m_tdata
);

    localparam int unsigned OFF_W = uf2ba_pkg::OFF_W;
    localparam int unsigned CNT_W = uf2ba_pkg::CNT_W;
    localparam int unsigned ROW_W = uf2ba_pkg::ROW_W;
    localparam int unsigned BIT_W = uf2ba_pkg::BIT_W;
    localparam int unsigned ROW_BITS = uf2ba_pkg::ROW_BITS;

    logic [31:0] family_reg;
    logic [31:0] base_reg;

    logic                 clearing_reg;
    logic [ROW_W-1:0]     clr_cnt_reg;

    logic                 a_vld_reg;
    uf2ba_pkg::hdr_t      a_hdr_reg;
    uf2ba_pkg::chk_t      a_chk;

    logic                 b_vld_reg;
    uf2ba_pkg::chk_t      b_chk_reg;
    logic [ROW_BITS-1:0]  rdata_reg;

    logic                 wr_vld_reg;
    logic [ROW_W-1:0]     wr_row_reg;
    logic [ROW_BITS-1:0]  wr_data_reg;

    logic [ROW_BITS-1:0]  map_mem [uf2ba_pkg::MAP_ROWS];

    logic [CNT_W-1:0]     session_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [OFF_W-1:0]     length_reg;
    logic                 complete_reg;

    logic [CNT_W-1:0]     session_next;
    logic [CNT_W-1:0]     count_next;
    logic [OFF_W-1:0]     length_next;
    logic                 complete_next;

    logic                 out_vld_reg;
    logic [uf2ba_pkg::OUT_W-1:0] out_data_reg;

    logic                 out_free;
    logic                 b_adv;
    logic                 a_adv;
    logic                 in_acc;

    logic [ROW_W-1:0]     a_row;
    logic [ROW_W-1:0]     b_row;
    logic [BIT_W-1:0]     b_bit;
    logic [ROW_BITS-1:0]  row_cur;
    logic [ROW_BITS-1:0]  row_new;
    logic                 bit_new;
    logic [OFF_W:0]       end_sum;
    logic                 past_image;
    uf2ba_pkg::reason_t   b_reason;
    logic                 b_ok;
    logic                 map_we;
    logic [uf2ba_pkg::OUT_W-1:0] out_word;

    // Handshake and stage movement.
    assign out_free = !out_vld_reg || m_tready;
    assign b_adv    = b_vld_reg && out_free;
    assign a_adv    = a_vld_reg && (!b_vld_reg || b_adv);
    assign s_tready = !clearing_reg && (!a_vld_reg || a_adv);
    assign in_acc   = s_tvalid && s_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    uf2ba_hdr_check u_check (
        .hdr             (a_hdr_reg),
        .expected_family (family_reg),
        .flash_base      (base_reg),
        .chk             (a_chk)
    );

    assign a_row = a_chk.bnum[CNT_W-1:BIT_W];
    assign b_row = b_chk_reg.bnum[CNT_W-1:BIT_W];
    assign b_bit = b_chk_reg.bnum[BIT_W-1:0];

    // Update stage: last checks against the session, then the map and counters.
    always_comb
    begin
        end_sum    = {1'b0, b_chk_reg.off} + {{(OFF_W+1-CNT_W){1'b0}}, b_chk_reg.psize};
        past_image = b_chk_reg.off_big || (end_sum > (OFF_W+1)'(uf2ba_pkg::IMAGE_BYTES));

        if (b_chk_reg.reason != uf2ba_pkg::RSN_OK)
        begin
            b_reason = b_chk_reg.reason;
        end
        else if (past_image)
        begin
            b_reason = uf2ba_pkg::RSN_IMAGE;
        end
        else if (b_chk_reg.total_bad)
        begin
            b_reason = uf2ba_pkg::RSN_TOTAL;
        end
        else if ((session_reg != '0) && (b_chk_reg.total != session_reg))
        begin
            b_reason = uf2ba_pkg::RSN_MISMATCH;
        end
        else
        begin
            b_reason = uf2ba_pkg::RSN_OK;
        end
        b_ok = (b_reason == uf2ba_pkg::RSN_OK);

        // The row written on the previous commit may not yet be in the read data.
        if (wr_vld_reg && (wr_row_reg == b_row))
        begin
            row_cur = wr_data_reg;
        end
        else
        begin
            row_cur = rdata_reg;
        end
        bit_new = !row_cur[b_bit];
        row_new = row_cur | (ROW_BITS'(1) << b_bit);

        session_next  = session_reg;
        count_next    = count_reg;
        length_next   = length_reg;
        complete_next = complete_reg;
        if (b_ok)
        begin
            // The map and counters are still at reset when the session opens.
            if (session_reg == '0)
            begin
                session_next = b_chk_reg.total;
            end
            if (end_sum[OFF_W-1:0] > length_reg)
            begin
                length_next = end_sum[OFF_W-1:0];
            end
            count_next = count_reg + CNT_W'(bit_new);
            if (count_next == session_next)
            begin
                complete_next = 1'b1;
            end
        end

        map_we = b_adv && b_ok;

        out_word = {complete_next, count_next, length_next,
                    (b_ok ? b_chk_reg.off : {OFF_W{1'b0}}), b_reason, b_ok};
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            family_reg <= uf2ba_pkg::FAMILY_RESET;
            base_reg   <= uf2ba_pkg::BASE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                uf2ba_pkg::CFG_FAMILY: family_reg <= cfg_data;
                uf2ba_pkg::CFG_BASE:   base_reg   <= cfg_data;
                default:               family_reg <= family_reg;
            endcase
        end
    end

    // Control state and session state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
            out_vld_reg  <= 1'b0;
            wr_vld_reg   <= 1'b0;
            session_reg  <= '0;
            count_reg    <= '0;
            length_reg   <= '0;
            complete_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                if (clr_cnt_reg == ROW_W'(uf2ba_pkg::MAP_ROWS - 1))
                begin
                    clearing_reg <= 1'b0;
                end
                else
                begin
                    clr_cnt_reg <= clr_cnt_reg + ROW_W'(1);
                end
            end

            if (in_acc)
            begin
                a_vld_reg <= 1'b1;
            end
            else if (a_adv)
            begin
                a_vld_reg <= 1'b0;
            end

            if (a_adv)
            begin
                b_vld_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                b_vld_reg <= 1'b0;
            end

            if (b_adv)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end

            if (map_we)
            begin
                wr_vld_reg   <= 1'b1;
                session_reg  <= session_next;
                count_reg    <= count_next;
                length_reg   <= length_next;
                complete_reg <= complete_next;
            end
        end
    end

    // Payload registers of the pipeline.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_hdr_reg.first_magic    <= s_tdata[31:0];
            a_hdr_reg.second_magic   <= s_tdata[63:32];
            a_hdr_reg.block_flags    <= s_tdata[95:64];
            a_hdr_reg.target_address <= s_tdata[127:96];
            a_hdr_reg.payload_bytes  <= s_tdata[159:128];
            a_hdr_reg.block_number   <= s_tdata[191:160];
            a_hdr_reg.total_blocks   <= s_tdata[223:192];
            a_hdr_reg.family_word    <= s_tdata[255:224];
            a_hdr_reg.closing_magic  <= s_tdata[287:256];
        end
        if (a_adv)
        begin
            b_chk_reg <= a_chk;
        end
        if (b_adv)
        begin
            out_data_reg <= out_word;
        end
        if (map_we)
        begin
            wr_row_reg  <= b_row;
            wr_data_reg <= row_new;
        end
    end

    // Received map memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            map_mem[clr_cnt_reg] <= '0;
        end
        else if (map_we)
        begin
            map_mem[b_row] <= row_new;
        end
        if (a_adv)
        begin
            rdata_reg <= map_mem[a_row];
        end
    end

`ifndef SYNTH
    a_accept_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == uf2ba_pkg::RSN_OK)))
        else $error("accepted flag disagrees with reject reason");

    a_count_within_map: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(uf2ba_pkg::MAX_BLOCKS))
        else $error("received count exceeds the number of map entries");

    a_complete_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        complete_reg |-> ((session_reg != '0) && (count_reg >= session_reg)))
        else $error("complete flag set without all blocks received");

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (!a_vld_reg && !b_vld_reg && !map_we))
        else $error("header in flight during map clearing");
`endif

endmodule
`default_nettype wire

// ----- bench/uf2_block_acceptor_test.sv -----
// Self-checking testbench for the UF2 block acceptor: directed plan, then random header beats.
module uf2_block_acceptor_test;
    import uf2ba_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned PHASES      = 5;
    localparam int unsigned PHASE_ITEMS = 160;
    localparam int unsigned CALM_ITEMS  = 30;

    // One block header, in the order the fields sit on s_tdata from the highest bit down.
    typedef struct packed {
        logic [31:0] closing_magic;
        logic [31:0] family_word;
        logic [31:0] total_blocks;
        logic [31:0] block_number;
        logic [31:0] payload_bytes;
        logic [31:0] target_address;
        logic [31:0] block_flags;
        logic [31:0] second_magic;
        logic [31:0] first_magic;
    } blk_t;

    // Status beat as it sits on m_tdata; the last member is the lowest bit.
    typedef struct packed {
        logic             complete;
        logic [CNT_W-1:0] count;
        logic [OFF_W-1:0] length;
        logic [OFF_W-1:0] offset;
        reason_t          reason;
        logic             accepted;
    } status_t;

    typedef struct {
        blk_t    hdr;
        bit      typed;
        status_t want;
    } plan_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [31:0]       cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    // Predictor copy of the configuration and the session.
    logic [31:0]           want_family;
    logic [31:0]           flash_base_q;
    logic [CNT_W-1:0]      open_total;
    logic [MAX_BLOCKS-1:0] seen;
    logic [CNT_W-1:0]      seen_count;
    logic [OFF_W-1:0]      high_water;
    logic                  all_seen;

    status_t     pending_status[$];
    plan_row_t   plan[$];
    status_t     got_status;
    status_t     want_status;
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned sess_blocks;
    int unsigned seq_bnum;
    int unsigned sink_hold;
    bit          calm;

    uf2_block_acceptor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Works out the status of one header and advances the session as the block would.
    function automatic status_t judge_block(input blk_t b);
        reason_t     why;
        logic [31:0] off;
        logic [32:0] stop;
        status_t     r;
        why  = RSN_OK;
        off  = '0;
        stop = '0;
        if (b.first_magic != MAGIC_FIRST || b.second_magic != MAGIC_SECOND ||
            b.closing_magic != MAGIC_CLOSE)
            why = RSN_MAGIC;
        else if (b.payload_bytes > PAYLOAD_MAX || b.block_number >= MAX_BLOCKS)
            why = RSN_SIZE;
        else if ((b.block_flags & FLAG_FAMILY) != 0 && b.family_word != want_family)
            why = RSN_FAMILY;
        else if (b.target_address < flash_base_q)
            why = RSN_BASE;
        else
        begin
            off  = b.target_address - flash_base_q;
            // The end of the payload is summed one bit wider so that it cannot wrap.
            stop = {1'b0, off} + {1'b0, b.payload_bytes};
            if (stop > IMAGE_BYTES)
                why = RSN_IMAGE;
            else if (b.total_blocks == 0 || b.total_blocks > MAX_BLOCKS)
                why = RSN_TOTAL;
            else if (open_total != 0 && b.total_blocks != {23'd0, open_total})
                why = RSN_MISMATCH;
        end
        if (why == RSN_OK)
        begin
            if (open_total == 0)
            begin
                open_total = b.total_blocks[CNT_W-1:0];
                seen       = '0;
                seen_count = '0;
                high_water = '0;
            end
            if (stop > high_water)
                high_water = stop[OFF_W-1:0];
            if (!seen[b.block_number[CNT_W-1:0]])
            begin
                seen[b.block_number[CNT_W-1:0]] = 1'b1;
                seen_count = seen_count + 1'b1;
            end
            if (seen_count == open_total)
                all_seen = 1'b1;
        end
        else
            off = '0;
        r.accepted = (why == RSN_OK);
        r.reason   = why;
        r.offset   = off[OFF_W-1:0];
        r.length   = high_water;
        r.count    = seen_count;
        r.complete = all_seen;
        return r;
    endfunction

    // A block that passes every check under the reset configuration.
    function automatic blk_t good_blk();
        blk_t b;
        b.first_magic    = MAGIC_FIRST;
        b.second_magic   = MAGIC_SECOND;
        b.block_flags    = '0;
        b.target_address = BASE_RESET;
        b.payload_bytes  = PAYLOAD_MAX;
        b.block_number   = '0;
        b.total_blocks   = sess_blocks;
        b.family_word    = '0;
        b.closing_magic  = MAGIC_CLOSE;
        return b;
    endfunction

    // Status of a rejected block while no session is open yet.
    function automatic status_t refused(input reason_t why);
        status_t s;
        s        = '0;
        s.reason = why;
        return s;
    endfunction

    function automatic void add_row(input blk_t b, input bit typed, input status_t want);
        plan_row_t row;
        row.hdr   = b;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endfunction

    function automatic blk_t random_blk();
        blk_t        b;
        int unsigned lim;
        int unsigned off;
        int unsigned pick;
        int unsigned t;
        logic [31:0] room;
        if ($urandom_range(0, 99) < 15)
        begin
            b.first_magic    = $urandom;
            b.second_magic   = $urandom;
            b.block_flags    = $urandom;
            b.target_address = $urandom;
            b.payload_bytes  = $urandom;
            b.block_number   = $urandom;
            b.total_blocks   = $urandom;
            b.family_word    = $urandom;
            b.closing_magic  = $urandom;
            return b;
        end
        b.first_magic   = MAGIC_FIRST;
        b.second_magic  = MAGIC_SECOND;
        b.closing_magic = MAGIC_CLOSE;
        b.block_flags   = $urandom & ~FLAG_FAMILY;
        if ($urandom_range(0, 1) == 1)
        begin
            b.block_flags = b.block_flags | FLAG_FAMILY;
            b.family_word = want_family;
        end
        else
            b.family_word = $urandom;
        b.payload_bytes = ($urandom_range(0, 3) == 0) ? PAYLOAD_MAX
                                                      : $urandom_range(0, PAYLOAD_MAX);
        // Keep the target inside the image and clear of the top of the address space.
        lim  = IMAGE_BYTES - b.payload_bytes;
        room = 32'hFFFF_FFFF - flash_base_q;
        if (room < lim)
            lim = room;
        off = ($urandom_range(0, 9) == 0) ? lim : $urandom_range(0, lim);
        b.target_address = flash_base_q + off;
        b.total_blocks   = sess_blocks;
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            // Walking the block numbers in order lets the count climb to its limit.
            if (pick < 68)
            begin
                b.block_number = seq_bnum;
                seq_bnum = (seq_bnum + 1) % MAX_BLOCKS;
            end
            else
                b.block_number = $urandom_range(0, MAX_BLOCKS - 1);
            return b;
        end
        b.block_number = $urandom_range(0, MAX_BLOCKS - 1);
        case ((pick - 80) % 9)
            0: b.first_magic = b.first_magic ^ (32'h1 << $urandom_range(0, 31));
            1: b.closing_magic = b.closing_magic ^ (32'h1 << $urandom_range(0, 31));
            2: b.payload_bytes = $urandom_range(PAYLOAD_MAX + 1, 32'hFFFF_FFFF);
            3: b.block_number = $urandom_range(MAX_BLOCKS, 32'hFFFF_FFFF);
            4:
            begin
                b.block_flags = b.block_flags | FLAG_FAMILY;
                b.family_word = want_family ^ (32'h1 << $urandom_range(0, 31));
            end
            5: b.target_address = flash_base_q - $urandom_range(1, 4096);
            6: b.target_address = flash_base_q + IMAGE_BYTES - b.payload_bytes
                                  + $urandom_range(1, 4096);
            7: b.total_blocks = ($urandom_range(0, 1) == 1) ? 0
                                : $urandom_range(MAX_BLOCKS + 1, 32'hFFFF_FFFF);
            default:
            begin
                t = sess_blocks + $urandom_range(1, MAX_BLOCKS - 1);
                if (t > MAX_BLOCKS)
                    t = t - MAX_BLOCKS;
                b.total_blocks = t;
            end
        endcase
        return b;
    endfunction

    // One register write, after which the write port is left idle.
    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FAMILY)
            want_family = val;
        else
            flash_base_q = val;
        @(posedge clk);
    endtask

    task automatic offer_block(input blk_t b, input bit typed, input status_t typed_st);
        status_t     p;
        int unsigned gap;
        s_tdata  <= {b.closing_magic, b.family_word, b.total_blocks, b.block_number,
                     b.payload_bytes, b.target_address, b.block_flags, b.second_magic,
                     b.first_magic};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        p = judge_block(b);
        pending_status.push_back(typed ? typed_st : p);
        gap = calm ? 0 : gap_len();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering beats and waits until every status beat has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            got_status = status_t'(m_tdata);
            if (pending_status.size() == 0)
            begin
                $display("%0t: status beat expected none, got %0h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want_status = pending_status.pop_front();
                check_field("accepted", want_status.accepted, got_status.accepted);
                check_field("reject_reason", want_status.reason, got_status.reason);
                check_field("write_offset", want_status.offset, got_status.offset);
                check_field("image_length", want_status.length, got_status.length);
                check_field("blocks_received", want_status.count, got_status.count);
                check_field("image_complete", want_status.complete, got_status.complete);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: runs of ready broken by stalls, none while the stream is calm.
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            sink_hold = calm ? 0 : gap_len();
            if (sink_hold != 0)
            begin
                m_tready <= 1'b0;
                repeat (sink_hold) @(posedge clk);
            end
        end
    end

    initial
    begin
        blk_t        b;
        int unsigned ph;
        int unsigned n;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_FAMILY;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        calm        = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        seq_bnum    = 0;
        want_family  = FAMILY_RESET;
        flash_base_q = BASE_RESET;
        open_total   = '0;
        seen         = '0;
        seen_count   = '0;
        high_water   = '0;
        all_seen     = 1'b0;
        sess_blocks  = $urandom_range(2, MAX_BLOCKS);

        // Rejections before the session opens leave every status field but the reason at zero.
        b = '0;
        add_row(b, 1'b1, refused(RSN_MAGIC));
        b = '1;
        add_row(b, 1'b1, refused(RSN_MAGIC));
        b = good_blk();
        b.second_magic = MAGIC_SECOND ^ 32'h1;
        add_row(b, 1'b1, refused(RSN_MAGIC));
        b = good_blk();
        b.closing_magic = MAGIC_CLOSE ^ 32'h8000_0000;
        add_row(b, 1'b1, refused(RSN_MAGIC));
        b = good_blk();
        b.payload_bytes = PAYLOAD_MAX + 1;
        add_row(b, 1'b1, refused(RSN_SIZE));
        b = good_blk();
        b.payload_bytes = 32'hFFFF_FFFF;
        add_row(b, 1'b1, refused(RSN_SIZE));
        b = good_blk();
        b.block_number = MAX_BLOCKS;
        add_row(b, 1'b1, refused(RSN_SIZE));
        b = good_blk();
        b.block_number = 32'hFFFF_FFFF;
        add_row(b, 1'b1, refused(RSN_SIZE));
        b = good_blk();
        b.block_flags = 32'hFFFF_FFFF;
        add_row(b, 1'b1, refused(RSN_FAMILY));
        b = good_blk();
        b.target_address = BASE_RESET - 1;
        add_row(b, 1'b1, refused(RSN_BASE));
        b = good_blk();
        b.target_address = '0;
        add_row(b, 1'b1, refused(RSN_BASE));
        b = good_blk();
        b.target_address = BASE_RESET + IMAGE_BYTES - PAYLOAD_MAX + 1;
        add_row(b, 1'b1, refused(RSN_IMAGE));
        b = good_blk();
        b.target_address = 32'hFFFF_FFFF;
        add_row(b, 1'b1, refused(RSN_IMAGE));
        b = good_blk();
        b.total_blocks = 0;
        add_row(b, 1'b1, refused(RSN_TOTAL));
        b = good_blk();
        b.total_blocks = MAX_BLOCKS + 1;
        add_row(b, 1'b1, refused(RSN_TOTAL));
        b = good_blk();
        b.total_blocks = 32'hFFFF_FFFF;
        add_row(b, 1'b1, refused(RSN_TOTAL));
        // Several faults at once: only the magic words are reported.
        b = good_blk();
        b.first_magic   = '0;
        b.payload_bytes = 32'hFFFF_FFFF;
        b.total_blocks  = 0;
        add_row(b, 1'b1, refused(RSN_MAGIC));
        // Opening block ends exactly at the image bound.
        b = good_blk();
        b.target_address = BASE_RESET + IMAGE_BYTES - PAYLOAD_MAX;
        b.block_flags    = FLAG_FAMILY;
        b.family_word    = FAMILY_RESET;
        add_row(b, 1'b1, '{1'b0, 9'd1, 17'd98304, 17'd98048, RSN_OK, 1'b1});
        // The same block number again is taken but not counted twice.
        b = good_blk();
        add_row(b, 1'b0, '0);
        b = good_blk();
        b.total_blocks = sess_blocks % MAX_BLOCKS + 1;
        add_row(b, 1'b0, '0);
        b = good_blk();
        b.block_number  = MAX_BLOCKS - 1;
        b.payload_bytes = 0;
        add_row(b, 1'b0, '0);
        b = good_blk();
        b.target_address = 32'hFFFF_FFFF;
        b.payload_bytes  = 0;
        add_row(b, 1'b0, '0);
        b = good_blk();
        b.block_flags   = 32'hFFFF_FFFF;
        b.family_word   = FAMILY_RESET;
        b.block_number  = 1;
        b.payload_bytes = 1;
        add_row(b, 1'b0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            offer_block(plan[i].hdr, plan[i].typed, plan[i].want);

        for (ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                1:
                begin
                    write_reg(CFG_FAMILY, 32'h0000_0000);
                    write_reg(CFG_BASE, 32'h0000_0000);
                end
                2:
                begin
                    write_reg(CFG_FAMILY, 32'hFFFF_FFFF);
                    write_reg(CFG_BASE, 32'hFFFF_FFFF);
                end
                3:
                begin
                    write_reg(CFG_FAMILY, $urandom);
                    write_reg(CFG_BASE, $urandom_range(0, 32'hFFFF_0000));
                end
                4:
                begin
                    write_reg(CFG_FAMILY, FAMILY_RESET);
                    write_reg(CFG_BASE, BASE_RESET);
                end
                default: ;
            endcase
            // Each phase opens with back-to-back beats on both sides.
            calm = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == CALM_ITEMS)
                    calm = 1'b0;
                offer_block(random_blk(), 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/uf2ba_pkg.sv
hw/rtl/uf2ba_hdr_check.sv
hw/rtl/uf2_block_acceptor.sv
bench/uf2_block_acceptor_test.sv
